// ----- design/serial_response_data_extractor_top_assert.svh -----
// Assertion macros shared by the serial response data extractor RTL.
`ifndef SERIAL_RESPONSE_DATA_EXTRACTOR_TOP_ASSERT_SVH
`define SERIAL_RESPONSE_DATA_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SRE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sre_pkg.sv -----
// Package with the types and constants of the serial response data extractor.
`default_nettype none

package sre_pkg;

    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int LEN_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam int LEN_INDEX_HI = 8;
    localparam int LEN_INDEX_LO = 9;
    localparam int DATA_START   = 10;
    localparam int LEN_MIN      = 2;
    localparam int LEN_MAX      = 16;

    localparam logic REG_EXTRACT_ENABLE = 1'b0;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LEN_A = 7'b0000010,
        S_LEN_B = 7'b0000100,
        S_LEN_C = 7'b0001000,
        S_READ  = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_SEND  = 7'b1000000
    } sre_state_t;

endpackage

`default_nettype wire

// ----- design/sre_if.sv -----
// Valid/ready stream interfaces for the received bytes and the response characters.
`default_nettype none

interface sre_rx_if;
    logic                          valid;
    logic                          ready;
    logic [sre_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sre_tx_if;
    logic                          valid;
    logic                          ready;
    logic [sre_pkg::CHAR_W-1:0]    out_char;
    logic                          char_valid;
    logic                          was_extracted;
    logic                          last_char;

    modport source (output valid, output out_char, output char_valid,
                    output was_extracted, output last_char, input ready);
    modport sink (input valid, input out_char, input char_valid,
                  input was_extracted, input last_char, output ready);
endinterface

`default_nettype wire

// ----- design/serial_response_data_extractor_top.sv -----
// Top level of the serial response data extractor: frame store, length decode and sequencer.
//
// Channel  Direction  Beat
// rx       in         rx_byte, one received serial byte
// tx       out        out_char, char_valid, was_extracted, last_char
// apb      in         extract_enable register at byte address 0
//
// A printable byte other than a carriage return is written to the frame store while it has room.
// A carriage return is accepted; each emitted beat is then read through the single store read
// port (states READ, LOAD, SEND), after the length field is fetched and decoded (states LEN_A,
// LEN_B, LEN_C) when extraction is tried. An empty frame goes straight to its single beat.
// rx is not ready until the last beat of a response has been taken on tx.
// tx stalls hold the sequencer in place; rst_n clears the count, state and register.
`default_nettype none

module serial_response_data_extractor_top #(
    parameter int RESPONSE_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sre_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sre_pkg::PDATA_W-1:0]   pwdata,
    output logic      [sre_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    sre_rx_if.sink                             rx,
    sre_tx_if.source                           tx
);

    localparam int CNT_W = $clog2(RESPONSE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(RESPONSE_DEPTH - 1);
    localparam logic [CNT_W-1:0] IDX_HI     = CNT_W'(sre_pkg::LEN_INDEX_HI);
    localparam logic [CNT_W-1:0] IDX_LO     = CNT_W'(sre_pkg::LEN_INDEX_LO);
    localparam logic [CNT_W-1:0] IDX_START  = CNT_W'(sre_pkg::DATA_START);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    function automatic logic [sre_pkg::LEN_W-1:0] parse_len(
        input logic [sre_pkg::CHAR_W-1:0] a,
        input logic [sre_pkg::CHAR_W-1:0] b
    );
        logic                          a_dig;
        logic                          b_dig;
        logic [sre_pkg::LEN_W-1:0]     a_val;
        logic [sre_pkg::LEN_W-1:0]     b_val;
        logic [sre_pkg::LEN_W-1:0]     v;
        a_dig = ({1'b0, a} >= sre_pkg::CHAR_ZERO) && ({1'b0, a} <= sre_pkg::CHAR_NINE);
        b_dig = ({1'b0, b} >= sre_pkg::CHAR_ZERO) && ({1'b0, b} <= sre_pkg::CHAR_NINE);
        a_val = {3'b000, a[3:0]};
        b_val = {3'b000, b[3:0]};
        v = '0;
        if (({1'b0, a} == sre_pkg::CHAR_SPACE) || ({1'b0, a} == sre_pkg::CHAR_PLUS))
        begin
            v = b_dig ? b_val : '0;
        end
        else if (a_dig)
        begin
            v = b_dig ? sre_pkg::LEN_W'(a_val * 7'd10 + b_val) : a_val;
        end
        // A minus sign gives a zero length, which falls outside the range.
        return v;
    endfunction

    logic [sre_pkg::CHAR_W-1:0] mem [RESPONSE_DEPTH];
    logic [sre_pkg::CHAR_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]           rd_addr;
    logic                       mem_we;

    sre_pkg::sre_state_t        state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       extract_enable_reg, extract_enable_next;
    logic [CNT_W-1:0]           frame_len_reg, frame_len_next;
    logic [CNT_W-1:0]           ptr_reg, ptr_next;
    logic [CNT_W-1:0]           end_ptr_reg, end_ptr_next;
    logic [sre_pkg::CHAR_W-1:0] char8_reg, char8_next;
    logic [sre_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic                       char_valid_reg, char_valid_next;
    logic                       ext_reg, ext_next;
    logic                       last_reg, last_next;

    logic                       rx_acc;
    logic                       tx_acc;
    logic                       is_printable;
    logic                       cfg_wr;
    logic [sre_pkg::LEN_W-1:0]  len_val;
    logic                       len_ok;
    logic [7:0]                 end_sum;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[sre_pkg::PADDR_W-1] == sre_pkg::REG_EXTRACT_ENABLE);
    assign prdata = (paddr[sre_pkg::PADDR_W-1] == sre_pkg::REG_EXTRACT_ENABLE)
                    ? {{(sre_pkg::PDATA_W-1){1'b0}}, extract_enable_reg}
                    : '0;

    assign rx.ready = (state_reg == sre_pkg::S_IDLE);
    assign rx_acc   = rx.valid && rx.ready;
    assign tx.valid = (state_reg == sre_pkg::S_SEND);
    assign tx_acc   = tx.valid && tx.ready;

    assign tx.out_char      = out_char_reg;
    assign tx.char_valid    = char_valid_reg;
    assign tx.was_extracted = ext_reg;
    assign tx.last_char     = last_reg;

    assign is_printable = (rx.rx_byte >= sre_pkg::CHAR_SPACE)
                          && (rx.rx_byte <= sre_pkg::CHAR_TILDE);
    assign mem_we = rx_acc && (rx.rx_byte != sre_pkg::CHAR_CR) && is_printable
                    && (count_reg < CNT_LIMIT);

    assign len_val = parse_len(char8_reg, rd_data_reg);
    assign len_ok  = (len_val >= sre_pkg::LEN_W'(sre_pkg::LEN_MIN))
                     && (len_val <= sre_pkg::LEN_W'(sre_pkg::LEN_MAX))
                     && (8'(frame_len_reg) > 8'(sre_pkg::DATA_START) + 8'(len_val));
    assign end_sum = 8'(sre_pkg::DATA_START) + 8'(len_val) - 8'd1;

    always_comb
    begin
        case (state_reg)
            sre_pkg::S_LEN_A: rd_addr = IDX_HI;
            sre_pkg::S_LEN_B: rd_addr = IDX_LO;
            default:          rd_addr = ptr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg] <= rx.rx_byte[sre_pkg::CHAR_W-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        extract_enable_next = extract_enable_reg;
        frame_len_next      = frame_len_reg;
        ptr_next            = ptr_reg;
        end_ptr_next        = end_ptr_reg;
        char8_next          = char8_reg;
        out_char_next       = out_char_reg;
        char_valid_next     = char_valid_reg;
        ext_next            = ext_reg;
        last_next           = last_reg;

        if (cfg_wr)
        begin
            extract_enable_next = pwdata[0];
        end

        if (mem_we)
        begin
            count_next = count_reg + CNT_ONE;
        end

        case (state_reg)
            sre_pkg::S_IDLE:
            begin
                if (rx_acc && (rx.rx_byte == sre_pkg::CHAR_CR))
                begin
                    count_next     = '0;
                    frame_len_next = count_reg;
                    ptr_next       = '0;
                    end_ptr_next   = count_reg - CNT_ONE;
                    ext_next       = 1'b0;
                    if (count_reg == '0)
                    begin
                        out_char_next   = '0;
                        char_valid_next = 1'b0;
                        last_next       = 1'b1;
                        state_next      = sre_pkg::S_SEND;
                    end
                    else if (extract_enable_reg && (count_reg > IDX_START))
                    begin
                        state_next = sre_pkg::S_LEN_A;
                    end
                    else
                    begin
                        state_next = sre_pkg::S_READ;
                    end
                end
            end
            sre_pkg::S_LEN_A:
            begin
                state_next = sre_pkg::S_LEN_B;
            end
            sre_pkg::S_LEN_B:
            begin
                char8_next = rd_data_reg;
                state_next = sre_pkg::S_LEN_C;
            end
            sre_pkg::S_LEN_C:
            begin
                if (len_ok)
                begin
                    ptr_next     = IDX_START;
                    end_ptr_next = end_sum[CNT_W-1:0];
                    ext_next     = 1'b1;
                end
                state_next = sre_pkg::S_READ;
            end
            sre_pkg::S_READ:
            begin
                state_next = sre_pkg::S_LOAD;
            end
            sre_pkg::S_LOAD:
            begin
                out_char_next   = rd_data_reg;
                char_valid_next = 1'b1;
                last_next       = (ptr_reg == end_ptr_reg);
                state_next      = sre_pkg::S_SEND;
            end
            sre_pkg::S_SEND:
            begin
                if (tx_acc)
                begin
                    if (last_reg)
                    begin
                        state_next = sre_pkg::S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + CNT_ONE;
                        state_next = sre_pkg::S_READ;
                    end
                end
            end
            default:
            begin
                state_next = sre_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= sre_pkg::S_IDLE;
            count_reg          <= '0;
            extract_enable_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            extract_enable_reg <= extract_enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_len_reg  <= frame_len_next;
        ptr_reg        <= ptr_next;
        end_ptr_reg    <= end_ptr_next;
        char8_reg      <= char8_next;
        out_char_reg   <= out_char_next;
        char_valid_reg <= char_valid_next;
        ext_reg        <= ext_next;
        last_reg       <= last_next;
    end

    `include "serial_response_data_extractor_top_assert.svh"

    `SRE_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_LIMIT, "frame count past limit")
    `SRE_ASSERT_NEXT(a_cr_clears, rx_acc && (rx.rx_byte == sre_pkg::CHAR_CR), count_reg == '0, "carriage return did not clear count")
    `SRE_ASSERT_IMPL(a_empty_beat, tx.valid && !tx.char_valid, tx.last_char && !tx.was_extracted, "empty response beat malformed")
    `SRE_ASSERT_IMPL(a_ptr_order, tx.valid && tx.char_valid, ptr_reg <= end_ptr_reg, "read pointer passed end of response")
    `SRE_ASSERT_IMPL(a_ext_in_frame, tx.valid && tx.was_extracted, end_ptr_reg < frame_len_reg, "extracted field exceeds frame")

endmodule

`default_nettype wire

// ----- tb/sv/tb_sre_score_pkg.sv -----
`timescale 1ns / 100ps
// Response predictor and scoreboard for the serial response data extractor testbench.
package tb_sre_score_pkg;
    import sre_pkg::*;

    localparam int FRAME_DEPTH = 64;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              was_extracted;
        logic              last_char;
    } resp_beat_t;

    // Length field under atoi rules: spaces, one optional sign, then digits; -1 if negative.
    function automatic int field_length(logic [CHAR_W-1:0] hi, logic [CHAR_W-1:0] lo);
        logic [CHAR_W-1:0] s [2];
        int                i;
        int                v;
        bit                neg;
        s[0] = hi;
        s[1] = lo;
        i = 0;
        v = 0;
        neg = 1'b0;
        while (i < 2 && s[i] == CHAR_SPACE)
        begin
            i++;
        end
        if (i < 2 && (s[i] == CHAR_PLUS || s[i] == CHAR_MINUS))
        begin
            neg = (s[i] == CHAR_MINUS);
            i++;
        end
        while (i < 2 && s[i] >= CHAR_ZERO && s[i] <= CHAR_NINE)
        begin
            v = v * 10 + (int'(s[i]) - int'(CHAR_ZERO));
            i++;
        end
        return (neg && v != 0) ? -1 : v;
    endfunction

    class response_scoreboard;
        resp_beat_t        pending [$];
        logic [CHAR_W-1:0] frame_chars [FRAME_DEPTH];
        int                frame_len;
        bit                extract_on;
        int                mismatches;
        int                bytes_seen;
        int                beats_seen;
        int                frames;
        int                extracted;
        int                dropped;

        function new();
            frame_len = 0;
            extract_on = 1'b0;
            mismatches = 0;
            bytes_seen = 0;
            beats_seen = 0;
            frames = 0;
            extracted = 0;
            dropped = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%t ERROR: %s", $realtime, msg);
            end
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            resp_beat_t beat;
            int         first;
            int         count;
            int         d;
            int         k;
            bytes_seen++;
            if (b != CHAR_CR)
            begin
                if (b >= CHAR_SPACE && b <= CHAR_TILDE)
                begin
                    if (frame_len < FRAME_DEPTH - 1)
                    begin
                        frame_chars[frame_len] = b[CHAR_W-1:0];
                        frame_len++;
                    end
                    else
                    begin
                        dropped++;
                    end
                end
                return;
            end
            frames++;
            first = 0;
            count = frame_len;
            beat = '0;
            if (extract_on && frame_len > DATA_START)
            begin
                d = field_length(frame_chars[LEN_INDEX_HI], frame_chars[LEN_INDEX_LO]);
                if (d >= LEN_MIN && d <= LEN_MAX && frame_len > DATA_START + d)
                begin
                    first = DATA_START;
                    count = d;
                    beat.was_extracted = 1'b1;
                    extracted++;
                end
            end
            frame_len = 0;
            if (count == 0)
            begin
                beat.last_char = 1'b1;
                pending.push_back(beat);
                return;
            end
            for (k = 0; k < count; k++)
            begin
                beat.out_char = frame_chars[first + k];
                beat.char_valid = 1'b1;
                beat.last_char = (k == count - 1);
                pending.push_back(beat);
            end
        endfunction

        function void check_beat(resp_beat_t got);
            resp_beat_t want;
            beats_seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat: char %02h valid %0b extracted %0b last %0b",
                                 got.out_char, got.char_valid, got.was_extracted,
                                 got.last_char));
                return;
            end
            want = pending.pop_front();
            if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
                got.was_extracted !== want.was_extracted || got.last_char !== want.last_char)
            begin
                report($sformatf({"beat %0d: expected char %02h valid %0b extracted %0b last %0b,",
                                  " got char %02h valid %0b extracted %0b last %0b"},
                                 beats_seen, want.out_char, want.char_valid, want.was_extracted,
                                 want.last_char, got.out_char, got.char_valid,
                                 got.was_extracted, got.last_char));
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_serial_response_data_extractor_top.sv -----
`timescale 1ns / 100ps
// Testbench top that feeds random serial frames to the extractor and checks every response beat.
module tb_serial_response_data_extractor_top;
    import sre_pkg::*;
    import tb_sre_score_pkg::*;

    localparam int IDLE_PCT  = 23;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE    = 20;
    localparam logic [PADDR_W-1:0] EXTRACT_ADDR = PADDR_W'(4 * int'(REG_EXTRACT_ENABLE));

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 idle_pct = IDLE_PCT;
    bit                 hold_req = 1'b0;
    int                 stored_bytes = 0;
    response_scoreboard resp_sb;

    sre_rx_if rx();
    sre_tx_if tx();

    serial_response_data_extractor_top #(
        .RESPONSE_DEPTH(FRAME_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .rx(rx),
        .tx(tx)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [BYTE_W-1:0] printable();
        return BYTE_W'($urandom_range(int'(CHAR_SPACE), int'(CHAR_TILDE)));
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1) == 0)
        begin
            b = BYTE_W'($urandom_range(0, int'(CHAR_SPACE) - 1));
            if (b == CHAR_CR)
            begin
                b = '0;
            end
        end
        else
        begin
            b = BYTE_W'($urandom_range(int'(CHAR_TILDE) + 1, 255));
        end
        return b;
    endfunction

    function automatic logic [2*BYTE_W-1:0] length_field();
        logic [BYTE_W-1:0] digit;
        logic [BYTE_W-1:0] signs [3];
        int                v;
        digit = CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
        signs[0] = CHAR_SPACE;
        signs[1] = CHAR_PLUS;
        signs[2] = CHAR_MINUS;
        v = $urandom_range(LEN_MIN, LEN_MAX);
        case ($urandom_range(0, 7))
            0: return {CHAR_ZERO + BYTE_W'(v / 10), CHAR_ZERO + BYTE_W'(v % 10)};
            1: return {CHAR_SPACE, digit};
            2: return {CHAR_PLUS, digit};
            3: return {CHAR_MINUS, digit};
            4: return {digit, printable()};
            5: return {CHAR_ZERO + BYTE_W'($urandom_range(0, 9)), digit};
            6: return {printable(), printable()};
            default: return {signs[$urandom_range(0, 2)], signs[$urandom_range(0, 2)]};
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            rx.valid = 1'b0;
            @(negedge clk);
        end
        rx.valid = 1'b1;
        rx.rx_byte = b;
        @(posedge clk);
        while (!rx.ready)
        begin
            @(posedge clk);
        end
        resp_sb.take_byte(b);
        if (b == CHAR_CR || (b >= CHAR_SPACE && b <= CHAR_TILDE))
        begin
            stored_bytes++;
        end
        @(negedge clk);
    endtask

    task automatic wait_for_responses();
        rx.valid = 1'b0;
        while (!resp_sb.drained())
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_extract(input bit on);
        logic [PDATA_W-1:0] readback;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = EXTRACT_ADDR;
        pwdata = PDATA_W'(on);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        readback = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        resp_sb.extract_on = on;
        if (readback !== PDATA_W'(on))
        begin
            resp_sb.report($sformatf("extract_enable read back %0h after writing %0b",
                                     readback, on));
        end
    endtask

    // Mostly well-formed frames with a length field, plus plain, noisy and over-long frames.
    task automatic random_phase(input int budget, input bit long_first);
        logic [BYTE_W-1:0]   frame [$];
        logic [2*BYTE_W-1:0] lf;
        int                  start_count;
        int                  kind;
        int                  n;
        int                  d;
        int                  tail;
        start_count = stored_bytes;
        while (stored_bytes - start_count < budget)
        begin
            frame.delete();
            kind = long_first ? 99 : $urandom_range(0, 99);
            long_first = 1'b0;
            if (kind < 55)
            begin
                repeat (8) frame.push_back(printable());
                lf = length_field();
                frame.push_back(lf[2*BYTE_W-1:BYTE_W]);
                frame.push_back(lf[BYTE_W-1:0]);
                d = field_length(lf[BYTE_W+CHAR_W-1:BYTE_W], lf[CHAR_W-1:0]);
                if (d < LEN_MIN || d > LEN_MAX)
                begin
                    d = $urandom_range(0, LEN_MAX);
                end
                case ($urandom_range(0, 3))
                    0: tail = d;
                    1: tail = d + 1;
                    2: tail = $urandom_range(0, 2);
                    default: tail = $urandom_range(d, d + 8);
                endcase
                repeat (tail) frame.push_back(printable());
                frame.push_back(CHAR_CR);
            end
            else if (kind < 82)
            begin
                n = $urandom_range(0, 20);
                repeat (n) frame.push_back(printable());
                frame.push_back(CHAR_CR);
            end
            else if (kind < 97)
            begin
                n = $urandom_range(1, 6);
                repeat (n) frame.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(FRAME_DEPTH - 4, FRAME_DEPTH + 6);
                repeat (n) frame.push_back(printable());
                frame.push_back(CHAR_CR);
            end
            foreach (frame[i])
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    send_byte(noise_byte());
                end
                send_byte(frame[i]);
            end
        end
        send_byte(CHAR_CR);
    endtask

    initial
    begin
        int       hold_left;
        resp_beat_t got;
        hold_left = 0;
        tx.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                tx.ready = 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                tx.ready = 1'b0;
            end
            else
            begin
                tx.ready = ($urandom_range(0, 99) >= idle_pct);
            end
            @(posedge clk);
            if (tx.valid && tx.ready)
            begin
                got = {tx.out_char, tx.char_valid, tx.was_extracted, tx.last_char};
                resp_sb.check_beat(got);
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] opening [$];
        string             field_frame;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx.valid = 1'b0;
        rx.rx_byte = '0;
        resp_sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty frame, ignored control and high bytes, then the printable extremes.
        set_extract(1'b0);
        opening = '{CHAR_CR, 8'h00, 8'h7F, 8'hFF, 8'h1F, 8'h0C, 8'h0E,
                    CHAR_SPACE, CHAR_TILDE, CHAR_CR};
        foreach (opening[i])
        begin
            send_byte(opening[i]);
        end
        wait_for_responses();

        set_extract(1'b1);
        field_frame = "ABCDEFGH02xyz";
        foreach (field_frame[i])
        begin
            send_byte(BYTE_W'(field_frame[i]));
        end
        send_byte(CHAR_CR);

        random_phase(30, 1'b1);
        hold_req = 1'b1;
        random_phase(30, 1'b0);
        wait_for_responses();

        set_extract(1'b0);
        random_phase(25, 1'b0);
        wait_for_responses();
        random_phase(25, 1'b0);
        wait_for_responses();

        set_extract(1'b1);
        idle_pct = 0;
        random_phase(30, 1'b0);
        idle_pct = IDLE_PCT;
        random_phase(20, 1'b0);
        wait_for_responses();

        $display("Sent %0d bytes in %0d frames under both extract settings; %0d frames extracted,",
                 resp_sb.bytes_seen, resp_sb.frames, resp_sb.extracted);
        $display("%0d bytes dropped on a full store, %0d beats checked, %0d mismatches.",
                 resp_sb.dropped, resp_sb.beats_seen, resp_sb.mismatches);
        if (resp_sb.mismatches == 0 && resp_sb.drained())
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d beats still expected.", resp_sb.pending.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/sre_pkg.sv
design/sre_if.sv
design/serial_response_data_extractor_top.sv
tb/sv/tb_sre_score_pkg.sv
tb/sv/tb_serial_response_data_extractor_top.sv
